[hdl/bpps_pkg.sv]
`default_nettype none

package bpps_pkg;

  // Fixed field widths of the ports and registers.
  localparam int unsigned NOW_W       = 32;
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned PERIOD_W    = 26;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned LEVEL_W     = 7;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 26;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 16;

  // Defaults for the top level parameters.
  localparam int unsigned PHASE_FRAC_BITS_DEF = 24;
  localparam int unsigned COS_TABLE_BITS_DEF  = 10;

  // Palette limit: the configured count is clamped to this.
  localparam int unsigned PALETTE_MAX = 8;
  localparam int unsigned PAL_LIMIT   = (PALETTE_MAX < 8) ? PALETTE_MAX : 8;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10000);
  localparam logic                AUTO_RESET   = 1'b1;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(1);

  // Full intensity level.
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(100);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PERIOD = 2'd0,
    REG_AUTO   = 2'd1,
    REG_COUNT  = 2'd2
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROC,
    ST_DIV,
    ST_UPDATE,
    ST_LOOKUP,
    ST_EMIT
  } bpps_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;       // latch the accepted input item
    logic clr_tk;        // hold: forget the time base
    logic trigger;       // restart the breath and capture the time
    logic capture_time;  // first tick after a hold: capture the time only
    logic div_start;     // load the divider with the time delta
    logic div_step;      // one quotient bit
    logic update;        // advance the phase and the palette
    logic lookup;        // fetch the intensity for the current phase
    logic emit;          // load the output register
  } bpps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hold;
    logic start;
    logic playing;
    logic time_known;
    logic auto_rt;
  } bpps_stat_t;

  localparam longint          Q30_ONE    = 64'sd1073741824;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  // Cosine in Q30 by its Taylor series up to x^14, every term truncated.
  function automatic longint cos_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = longint'(Q30_ONE);
    sum  = Q30_ONE;
    term = ((term * x2) >> 30) / 2;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 12;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 30;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 56;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 90;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 132;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 182;
    sum  = sum - longint'(term);
    return sum;
  endfunction

  // One entry of the raised-cosine intensity curve, 0 to 100.
  function automatic logic [LEVEL_W-1:0] curve_entry(input int unsigned idx,
                                                     input int unsigned tbl_bits);
    longint unsigned n;
    longint unsigned j;
    longint          c;
    longint          v;
    n = longint'(1) << tbl_bits;
    j = (idx <= n / 2) ? longint'(idx) : n - longint'(idx);
    if (j <= n / 4) begin
      c = cos_q30((j * TWO_PI_Q30) >> tbl_bits);
    end else begin
      c = -cos_q30(((n / 2 - j) * TWO_PI_Q30) >> tbl_bits);
    end
    v = ((Q30_ONE - c) * 100) >>> 31;
    if (v < 0) begin
      v = 0;
    end
    if (v > 100) begin
      v = 100;
    end
    return LEVEL_W'(v);
  endfunction

endpackage

`default_nettype wire

[hdl/bpps_ctrl.sv]
`default_nettype none

module bpps_ctrl
  import bpps_pkg::*;
#(
  parameter int unsigned PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire bpps_stat_t stat,
  output bpps_cmd_t       cmd
);

  localparam int unsigned DIV_STEPS = NOW_W + PHASE_FRAC_BITS;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  bpps_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // State, step counter and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    // A waiting result leaves once the sink takes the transfer.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PROC;
        end
      end
      ST_PROC: begin
        if (stat.hold) begin
          cmd.clr_tk = 1'b1;
          state_nxt  = ST_EMIT;
        end else if (stat.start || (stat.auto_rt && !stat.playing)) begin
          cmd.trigger = 1'b1;
          state_nxt   = ST_LOOKUP;
        end else if (stat.playing && !stat.time_known) begin
          cmd.capture_time = 1'b1;
          state_nxt        = ST_LOOKUP;
        end else if (stat.playing) begin
          cmd.div_start = 1'b1;
          cnt_nxt       = CNT_W'(DIV_STEPS - 1);
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_UPDATE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        // The output register is free or is emptied in this cycle.
        if (!out_valid_r || out_tready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/bpps_dp.sv]
`default_nettype none

module bpps_dp
  import bpps_pkg::*;
#(
  parameter int unsigned PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF,
  parameter int unsigned COS_TABLE_BITS  = COS_TABLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire bpps_cmd_t              cmd,
  output bpps_stat_t                  stat,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int unsigned DIV_W    = NOW_W + PHASE_FRAC_BITS;
  localparam int unsigned TBL_SIZE = 1 << COS_TABLE_BITS;
  localparam logic [PHASE_W-1:0] ONE_CYCLE = PHASE_W'(1) << PHASE_FRAC_BITS;

  // Configuration registers.
  logic [PERIOD_W-1:0] period_r;
  logic                auto_r;
  logic [COUNT_W-1:0]  count_r;

  // Latched input item.
  logic [NOW_W-1:0] now_r;
  logic             hold_r;
  logic             start_r;

  // Breath state.
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [NOW_W-1:0]   last_r, last_nxt;
  logic               tk_r, tk_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               up_r, up_nxt;
  logic               play_r, play_nxt;
  logic [LEVEL_W-1:0] held_r, held_nxt;
  logic               done_r, done_nxt;

  // Divider: quotient shifts in as the dividend shifts out.
  logic [DIV_W-1:0]    qd_r, qd_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;
  logic [PERIOD_W-1:0] per_eff;
  logic [PERIOD_W:0]   rem_shift;
  logic [PERIOD_W:0]   rem_diff;
  logic                rem_ge;

  // Phase advance.
  logic [PHASE_W:0]   sum_ext;
  logic               sat;
  logic [PHASE_W-1:0] phase_sum;
  logic               wrap;

  // Palette stepping.
  logic [COUNT_W-1:0] n_eff;
  logic [COUNT_W-1:0] pos_inc;
  logic [POS_W-1:0]   pos_step;
  logic               up_step;

  logic [LEVEL_W-1:0]     curve_tbl [TBL_SIZE];
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Raised-cosine intensity table, fixed at elaboration.
  for (genvar g = 0; g < TBL_SIZE; g++) begin : g_curve
    assign curve_tbl[g] = curve_entry(g, COS_TABLE_BITS);
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      auto_r   <= AUTO_RESET;
      count_r  <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PERIOD: period_r <= cfg_data[PERIOD_W-1:0];
        REG_AUTO:   auto_r   <= cfg_data[0];
        REG_COUNT:  count_r  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input item latch, divider registers and output data register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r   <= in_tdata[NOW_W-1:0];
      hold_r  <= in_tdata[NOW_W];
      start_r <= in_tdata[NOW_W+1];
    end
    qd_r  <= qd_nxt;
    rem_r <= rem_nxt;
    if (cmd.emit) begin
      out_data_r <= {3'b000, done_r, play_r, pos_r, (held_r >= LEVEL_FULL), held_r};
    end
  end

  // Breath state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      last_r  <= '0;
      tk_r    <= 1'b0;
      pos_r   <= '0;
      up_r    <= 1'b1;
      play_r  <= 1'b0;
      held_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      last_r  <= last_nxt;
      tk_r    <= tk_nxt;
      pos_r   <= pos_nxt;
      up_r    <= up_nxt;
      play_r  <= play_nxt;
      held_r  <= held_nxt;
      done_r  <= done_nxt;
    end
  end

  // One restoring division step per cycle; a zero period counts as one.
  always_comb begin
    per_eff   = (period_r == '0) ? PERIOD_W'(1) : period_r;
    rem_shift = {rem_r, qd_r[DIV_W-1]};
    rem_diff  = rem_shift - {1'b0, per_eff};
    rem_ge    = (rem_shift >= {1'b0, per_eff});
    qd_nxt    = qd_r;
    rem_nxt   = rem_r;
    if (cmd.div_start) begin
      qd_nxt  = {now_r - last_r, {PHASE_FRAC_BITS{1'b0}}};
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      qd_nxt  = {qd_r[DIV_W-2:0], rem_ge};
      rem_nxt = rem_ge ? rem_diff[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
    end
  end

  // Saturating phase add and wrap detection.
  always_comb begin
    sum_ext   = {1'b0, phase_r} + {1'b0, qd_r[PHASE_W-1:0]};
    sat       = (|qd_r[DIV_W-1:PHASE_W]) || sum_ext[PHASE_W];
    phase_sum = sat ? '1 : sum_ext[PHASE_W-1:0];
    wrap      = |phase_sum[PHASE_W-1:PHASE_FRAC_BITS];
  end

  // Ping-pong palette step.
  always_comb begin
    if (count_r == '0) begin
      n_eff = COUNT_W'(1);
    end else if (count_r > COUNT_W'(PAL_LIMIT)) begin
      n_eff = COUNT_W'(PAL_LIMIT);
    end else begin
      n_eff = count_r;
    end
    pos_inc  = {1'b0, pos_r} + COUNT_W'(1);
    pos_step = pos_r;
    up_step  = up_r;
    if (n_eff > COUNT_W'(1)) begin
      if (up_r) begin
        if (pos_inc + COUNT_W'(1) >= n_eff) begin
          pos_step = POS_W'(n_eff - COUNT_W'(1));
          up_step  = 1'b0;
        end else begin
          pos_step = pos_inc[POS_W-1:0];
        end
      end else if (pos_r == '0) begin
        pos_step = POS_W'(1);
        up_step  = 1'b1;
      end else begin
        pos_step = pos_r - POS_W'(1);
      end
    end
  end

  // Next breath state under the controller's commands.
  always_comb begin
    phase_nxt = phase_r;
    last_nxt  = last_r;
    tk_nxt    = tk_r;
    pos_nxt   = pos_r;
    up_nxt    = up_r;
    play_nxt  = play_r;
    held_nxt  = held_r;
    done_nxt  = done_r;

    if (cmd.capture) begin
      done_nxt = 1'b0;
    end
    if (cmd.clr_tk) begin
      tk_nxt = 1'b0;
    end
    if (cmd.trigger) begin
      phase_nxt = '0;
      pos_nxt   = '0;
      up_nxt    = 1'b1;
      play_nxt  = 1'b1;
      last_nxt  = now_r;
      tk_nxt    = 1'b1;
    end
    if (cmd.capture_time) begin
      last_nxt = now_r;
      tk_nxt   = 1'b1;
    end
    if (cmd.update) begin
      last_nxt  = now_r;
      phase_nxt = wrap ? (phase_sum - ONE_CYCLE) : phase_sum;
      if (wrap) begin
        if (!auto_r) begin
          play_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          pos_nxt = pos_step;
          up_nxt  = up_step;
        end
      end
    end
    if (cmd.lookup) begin
      held_nxt = curve_tbl[phase_r[PHASE_FRAC_BITS-1 -: COS_TABLE_BITS]];
    end
  end

  assign stat.hold       = hold_r;
  assign stat.start      = start_r;
  assign stat.playing    = play_r;
  assign stat.time_known = tk_r;
  assign stat.auto_rt    = auto_r;

  assign out_tdata = out_data_r;

endmodule

`default_nettype wire

[hdl/breathing_phase_palette_sequencer_unit.sv]
// An advancing tick passes through the restoring divider, which forms one quotient
// bit per cycle, then the phase update, the table lookup and the output register;
// hold and stopped ticks go straight to the output register, trigger and time
// capture ticks through the table lookup. One item is in work at a time; the next
// transfer can be taken as soon as the result is registered, also while it still
// waits for the sink. Synchronous active-low reset resets the control and breath
// state and loads the register defaults; input, divider and output data are not.
`default_nettype none

module breathing_phase_palette_sequencer_unit
  import bpps_pkg::*;
#(
  parameter int unsigned PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF,
  parameter int unsigned COS_TABLE_BITS  = COS_TABLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration write port.
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // Input channel.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0: now_ms[31:0], hold[32], start_request[33], zero fill.
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // Result channel.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // Fields from bit 0: intensity[6:0], full_on[7], color_index[10:8],
  // running[11], cycle_done[12], zero fill.
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  bpps_cmd_t  cmd;
  bpps_stat_t stat;

  bpps_ctrl #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bpps_dp #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire
